@@ rtl/bcbt_pkg.sv @@
`default_nettype none

package bcbt_pkg;

   localparam int GRID_SIDE_DEF  = 28;
   localparam int BLOCK_SIDE_DEF = 9;
   localparam int MAX_BRUSH_DEF  = 9;

   // Coordinates are signed and cover the widest canvas in the parameter range.
   localparam int CRD_W  = 11;
   localparam int SPAN_W = 5;
   localparam int SIZE_W = 4;
   localparam int THR_W  = 15;

   localparam logic [SIZE_W-1:0] BRUSH_SIZE_RESET = 4'd9;
   localparam logic [THR_W-1:0]  THRESHOLD_RESET  = 15'd324;
   localparam logic [7:0]        PIXEL_MAX        = 8'd255;

   localparam logic REG_BRUSH_SIZE = 1'b0;
   localparam logic REG_THRESHOLD  = 1'b1;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_STAMP  = 2'd1,
      CMD_EVAL   = 2'd2,
      CMD_UNUSED = 2'd3
   } cmd_type;

   typedef enum logic [1:0] {
      OP_SKIP  = 2'd0,
      OP_LOAD  = 2'd1,
      OP_STAMP = 2'd2,
      OP_EVAL  = 2'd3
   } op_type;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] center_x;
      logic [7:0] center_y;
      logic [6:0] brush_index;
      logic [7:0] brush_shade;
      logic [4:0] block_x;
      logic [4:0] block_y;
   } req_type;

   typedef struct packed {
      logic [1:0] done_cmd;
      logic       block_flag;
   } rsp_type;

   typedef struct packed {
      op_type                    op;
      logic [1:0]                cmd;
      logic signed [CRD_W-1:0]   x0;
      logic signed [CRD_W-1:0]   y0;
      logic [SPAN_W-1:0]         span;
      logic [SIZE_W-1:0]         stride;
      logic [6:0]                brush_index;
      logic [7:0]                brush_shade;
      logic [4:0]                block_x;
      logic [4:0]                block_y;
   } job_type;

endpackage

`default_nettype wire

@@ rtl/bcbt_queue.sv @@
`default_nettype none

module bcbt_queue (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  bcbt_pkg::job_type      push_job,
   output logic                   full,
   input  wire logic              pop,
   output bcbt_pkg::job_type      head_job,
   output logic                   empty
);

   localparam int DEPTH = 2;

   bcbt_pkg::job_type entries_ff [DEPTH];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   always_comb begin
      full     = (count_ff == 2'(DEPTH));
      empty    = (count_ff == 2'd0);
      do_push  = push && !full;
      do_pop   = pop && !empty;
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + 2'(do_push) - 2'(do_pop);
      head_job  = entries_ff[rd_ptr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entries_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bcbt_front.sv @@
`default_nettype none

module bcbt_front #(
   parameter int GRID_SIDE  = bcbt_pkg::GRID_SIDE_DEF,
   parameter int BLOCK_SIDE = bcbt_pkg::BLOCK_SIDE_DEF,
   parameter int MAX_BRUSH  = bcbt_pkg::MAX_BRUSH_DEF
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        start,
   output logic                             busy,
   input  bcbt_pkg::req_type                req_item,
   input  wire logic [bcbt_pkg::SIZE_W-1:0] brush_size,
   input  wire logic                        clearing,
   input  wire logic                        q_full,
   output logic                             q_push,
   output bcbt_pkg::job_type                q_job
);

   localparam int BRUSH_DEPTH = MAX_BRUSH * MAX_BRUSH;

   bcbt_pkg::job_type            slot_ff, slot_in;
   logic                         slot_valid_ff, slot_valid_in;
   logic                         accept;
   logic [bcbt_pkg::SIZE_W-1:0]  size;
   logic [bcbt_pkg::SIZE_W-1:0]  half;

   always_comb begin
      size = brush_size;
      if (size == '0) begin
         size = bcbt_pkg::SIZE_W'(1);
      end else if (int'(size) > MAX_BRUSH) begin
         size = bcbt_pkg::SIZE_W'(MAX_BRUSH);
      end
      half = (size - bcbt_pkg::SIZE_W'(1)) >> 1;

      slot_in             = '0;
      slot_in.op          = bcbt_pkg::OP_SKIP;
      slot_in.cmd         = req_item.cmd;
      slot_in.brush_index = req_item.brush_index;
      slot_in.brush_shade = req_item.brush_shade;
      slot_in.block_x     = req_item.block_x;
      slot_in.block_y     = req_item.block_y;
      slot_in.stride      = size;
      case (req_item.cmd)
         bcbt_pkg::CMD_LOAD: begin
            if (int'(req_item.brush_index) < BRUSH_DEPTH) begin
               slot_in.op = bcbt_pkg::OP_LOAD;
            end
         end
         bcbt_pkg::CMD_STAMP: begin
            slot_in.op   = bcbt_pkg::OP_STAMP;
            slot_in.x0   = bcbt_pkg::CRD_W'(req_item.center_x) - bcbt_pkg::CRD_W'(half);
            slot_in.y0   = bcbt_pkg::CRD_W'(req_item.center_y) - bcbt_pkg::CRD_W'(half);
            slot_in.span = bcbt_pkg::SPAN_W'({half, 1'b1});
         end
         bcbt_pkg::CMD_EVAL: begin
            if (int'(req_item.block_x) < GRID_SIDE && int'(req_item.block_y) < GRID_SIDE) begin
               slot_in.op   = bcbt_pkg::OP_EVAL;
               slot_in.x0   = bcbt_pkg::CRD_W'(req_item.block_x) *
                              bcbt_pkg::CRD_W'(BLOCK_SIDE);
               slot_in.y0   = bcbt_pkg::CRD_W'(req_item.block_y) *
                              bcbt_pkg::CRD_W'(BLOCK_SIDE);
               slot_in.span = bcbt_pkg::SPAN_W'(BLOCK_SIDE);
            end
         end
         default: begin
            slot_in.op = bcbt_pkg::OP_SKIP;
         end
      endcase

      busy   = clearing || (slot_valid_ff && q_full);
      accept = start && !busy;
      q_push = slot_valid_ff && !q_full;
      q_job  = slot_ff;
      if (accept) begin
         slot_valid_in = 1'b1;
      end else if (q_push) begin
         slot_valid_in = 1'b0;
      end else begin
         slot_valid_in = slot_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= 1'b0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         slot_ff <= slot_in;
      end
   end

endmodule

`default_nettype wire

@@ rtl/bcbt_back.sv @@
`default_nettype none

module bcbt_back #(
   parameter int GRID_SIDE  = bcbt_pkg::GRID_SIDE_DEF,
   parameter int BLOCK_SIDE = bcbt_pkg::BLOCK_SIDE_DEF,
   parameter int MAX_BRUSH  = bcbt_pkg::MAX_BRUSH_DEF
) (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       q_empty,
   input  bcbt_pkg::job_type               q_head,
   output logic                            q_pop,
   output logic                            clearing,
   input  wire logic [bcbt_pkg::THR_W-1:0] threshold,
   output logic                            rsp_valid,
   output bcbt_pkg::rsp_type               rsp_item
);

   localparam int CANVAS_SIDE = GRID_SIDE * BLOCK_SIDE;
   localparam int CANVAS_PIX  = CANVAS_SIDE * CANVAS_SIDE;
   localparam int CELLS       = GRID_SIDE * GRID_SIDE;
   localparam int BRUSH_DEPTH = MAX_BRUSH * MAX_BRUSH;
   localparam int ADDR_W      = (CANVAS_PIX > 1) ? $clog2(CANVAS_PIX) : 1;
   localparam int CELL_W      = (CELLS > 1) ? $clog2(CELLS) : 1;
   localparam int BA_W        = (BRUSH_DEPTH > 1) ? $clog2(BRUSH_DEPTH) : 1;
   localparam int SUM_W       = $clog2(BLOCK_SIDE * BLOCK_SIDE * 255 + 1);
   localparam int CRD_W       = bcbt_pkg::CRD_W;
   localparam int SPAN_W      = bcbt_pkg::SPAN_W;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_FLAG,
      S_WALK,
      S_DRAIN,
      S_FLUSH,
      S_FINISH
   } state_type;

   state_type state_ff;

   logic [7:0] canvas_mem [CANVAS_PIX];
   logic       flag_mem   [CELLS];
   logic [7:0] brush_mem  [BRUSH_DEPTH];

   logic [ADDR_W-1:0]              clr_ff;
   bcbt_pkg::op_type               job_op_ff;
   logic [1:0]                     job_cmd_ff;
   logic signed [CRD_W-1:0]        job_x0_ff;
   logic signed [CRD_W-1:0]        job_y0_ff;
   logic [SPAN_W-1:0]              job_span_ff;
   logic [bcbt_pkg::SIZE_W-1:0]    job_stride_ff;
   logic [CELL_W-1:0]              job_cell_ff;
   logic [SPAN_W-1:0]              col_ff;
   logic [SPAN_W-1:0]              row_ff;
   logic [BA_W-1:0]                brow_ff;
   logic [SUM_W-1:0]               sum_ff;
   logic                           a_valid_ff;
   logic [ADDR_W-1:0]              a_caddr_ff;
   logic [BA_W-1:0]                a_baddr_ff;
   logic                           b_valid_ff;
   logic [ADDR_W-1:0]              b_caddr_ff;
   logic [7:0]                     canvas_q_ff;
   logic [7:0]                     brush_q_ff;
   logic                           flag_q_ff;
   logic                           rsp_valid_ff;
   bcbt_pkg::rsp_type              rsp_item_ff;

   logic signed [CRD_W-1:0] x_c;
   logic signed [CRD_W-1:0] y_c;
   logic                    inside_c;
   logic [ADDR_W-1:0]       caddr_c;
   logic [BA_W-1:0]         baddr_c;
   logic                    col_last;
   logic                    row_last;
   logic                    clear_last;
   logic [CELL_W-1:0]       cell_c;
   logic [8:0]              pix_sum;
   logic [7:0]              pix_sat;
   logic                    hit;
   logic                    cv_we;
   logic [ADDR_W-1:0]       cv_waddr;
   logic [7:0]              cv_wdata;
   logic                    fl_we;
   logic [CELL_W-1:0]       fl_waddr;
   logic                    fl_wdata;
   logic                    br_we;

   always_comb begin
      x_c      = job_x0_ff + CRD_W'(col_ff);
      y_c      = job_y0_ff + CRD_W'(row_ff);
      inside_c = !x_c[CRD_W-1] && !y_c[CRD_W-1] &&
                 (int'(x_c[CRD_W-2:0]) < CANVAS_SIDE) &&
                 (int'(y_c[CRD_W-2:0]) < CANVAS_SIDE);
      caddr_c  = ADDR_W'(y_c[CRD_W-2:0]) * ADDR_W'(CANVAS_SIDE) +
                 ADDR_W'(x_c[CRD_W-2:0]);
      baddr_c  = brow_ff + BA_W'(col_ff);
      col_last = (col_ff == job_span_ff - SPAN_W'(1));
      row_last = (row_ff == job_span_ff - SPAN_W'(1));
      clear_last = (int'(clr_ff) == CANVAS_PIX - 1);
      cell_c   = CELL_W'(q_head.block_y) * CELL_W'(GRID_SIDE) + CELL_W'(q_head.block_x);
      pix_sum  = {1'b0, canvas_q_ff} + {1'b0, brush_q_ff};
      pix_sat  = pix_sum[8] ? bcbt_pkg::PIXEL_MAX : pix_sum[7:0];
      hit      = (int'(sum_ff) >= int'(threshold));
      clearing = (state_ff == S_CLEAR);
      q_pop    = (state_ff == S_IDLE) && !q_empty;
      br_we    = q_pop && (q_head.op == bcbt_pkg::OP_LOAD);

      if (clearing) begin
         cv_we    = 1'b1;
         cv_waddr = clr_ff;
         cv_wdata = 8'd0;
         fl_we    = (int'(clr_ff) < CELLS);
         fl_waddr = CELL_W'(clr_ff);
         fl_wdata = 1'b0;
      end else begin
         cv_we    = b_valid_ff && (job_op_ff == bcbt_pkg::OP_STAMP);
         cv_waddr = b_caddr_ff;
         cv_wdata = pix_sat;
         fl_we    = (state_ff == S_FINISH) && (job_op_ff == bcbt_pkg::OP_EVAL) && hit;
         fl_waddr = job_cell_ff;
         fl_wdata = 1'b1;
      end

      rsp_valid = rsp_valid_ff;
      rsp_item  = rsp_item_ff;
   end

   always_ff @(posedge clock) begin
      if (cv_we) begin
         canvas_mem[cv_waddr] <= cv_wdata;
      end
      canvas_q_ff <= canvas_mem[a_caddr_ff];
   end

   always_ff @(posedge clock) begin
      if (fl_we) begin
         flag_mem[fl_waddr] <= fl_wdata;
      end
      flag_q_ff <= flag_mem[cell_c];
   end

   always_ff @(posedge clock) begin
      if (br_we) begin
         brush_mem[BA_W'(q_head.brush_index)] <= q_head.brush_shade;
      end
      brush_q_ff <= brush_mem[a_baddr_ff];
   end

   always_ff @(posedge clock) begin
      a_caddr_ff <= caddr_c;
      a_baddr_ff <= baddr_c;
      b_caddr_ff <= a_caddr_ff;
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         a_valid_ff   <= 1'b0;
         b_valid_ff   <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         a_valid_ff   <= (state_ff == S_WALK) && inside_c;
         b_valid_ff   <= a_valid_ff;
         if (b_valid_ff) begin
            sum_ff <= sum_ff + SUM_W'(canvas_q_ff);
         end
         case (state_ff)
            S_CLEAR: begin
               clr_ff <= clr_ff + ADDR_W'(1);
               if (clear_last) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (!q_empty) begin
                  job_op_ff     <= q_head.op;
                  job_cmd_ff    <= q_head.cmd;
                  job_x0_ff     <= q_head.x0;
                  job_y0_ff     <= q_head.y0;
                  job_span_ff   <= q_head.span;
                  job_stride_ff <= q_head.stride;
                  job_cell_ff   <= cell_c;
                  col_ff        <= '0;
                  row_ff        <= '0;
                  brow_ff       <= '0;
                  sum_ff        <= '0;
                  case (q_head.op)
                     bcbt_pkg::OP_STAMP: begin
                        state_ff <= S_WALK;
                     end
                     bcbt_pkg::OP_EVAL: begin
                        state_ff <= S_FLAG;
                     end
                     default: begin
                        rsp_valid_ff           <= 1'b1;
                        rsp_item_ff.done_cmd   <= q_head.cmd;
                        rsp_item_ff.block_flag <= 1'b0;
                     end
                  endcase
               end
            end
            S_FLAG: begin
               if (flag_q_ff) begin
                  rsp_valid_ff           <= 1'b1;
                  rsp_item_ff.done_cmd   <= job_cmd_ff;
                  rsp_item_ff.block_flag <= 1'b1;
                  state_ff               <= S_IDLE;
               end else begin
                  state_ff <= S_WALK;
               end
            end
            S_WALK: begin
               if (col_last) begin
                  col_ff  <= '0;
                  row_ff  <= row_ff + SPAN_W'(1);
                  brow_ff <= brow_ff + BA_W'(job_stride_ff);
                  if (row_last) begin
                     state_ff <= S_DRAIN;
                  end
               end else begin
                  col_ff <= col_ff + SPAN_W'(1);
               end
            end
            S_DRAIN: begin
               state_ff <= S_FLUSH;
            end
            S_FLUSH: begin
               state_ff <= S_FINISH;
            end
            S_FINISH: begin
               rsp_valid_ff           <= 1'b1;
               rsp_item_ff.done_cmd   <= job_cmd_ff;
               rsp_item_ff.block_flag <= (job_op_ff == bcbt_pkg::OP_EVAL) && hit;
               state_ff               <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

`default_nettype wire

@@ rtl/brush_canvas_block_threshold_core.sv @@
`default_nettype none

// Channel   Dir  Ports                                      Beat taken when
// request   in   start, busy, req_item                      start && !busy
// response  out  rsp_valid, rsp_item                        rsp_valid (one cycle)
// config    in   psel, penable, pwrite, paddr, pwdata,      psel && penable &&
//                prdata, pready                             pwrite && pready
//
// A load, an unused command or an evaluate off the grid is answered from the idle state
// once it reaches the head of the queue. An evaluate of a cell whose flag is already set
// is answered from the flag check. A stamp walks a (2*half+1)-square window and an evaluate
// a BLOCK_SIDE-square block, one pixel per cycle, through the canvas memory's read and write
// ports. After reset the canvas and flag memories are cleared one entry per cycle, with busy
// high. The receiver cannot stall: each result is shown for one cycle.
// Up to three commands wait ahead of the one being executed.

module brush_canvas_block_threshold_core #(
   parameter int GRID_SIDE  = bcbt_pkg::GRID_SIDE_DEF,
   parameter int BLOCK_SIDE = bcbt_pkg::BLOCK_SIDE_DEF,
   parameter int MAX_BRUSH  = bcbt_pkg::MAX_BRUSH_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  bcbt_pkg::req_type req_item,
   output logic             rsp_valid,
   output bcbt_pkg::rsp_type rsp_item,
   input  wire logic        psel,
   input  wire logic        penable,
   input  wire logic        pwrite,
   input  wire logic [2:0]  paddr,
   input  wire logic [31:0] pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);

   logic [bcbt_pkg::SIZE_W-1:0] brush_size_ff;
   logic [bcbt_pkg::THR_W-1:0]  threshold_ff;
   logic                        csr_write;
   logic                        clearing;
   logic                        q_push;
   logic                        q_full;
   logic                        q_pop;
   logic                        q_empty;
   bcbt_pkg::job_type           q_job;
   bcbt_pkg::job_type           q_head;

   always_comb begin
      pready    = 1'b1;
      csr_write = psel && penable && pwrite && pready;
      if (paddr[2] == bcbt_pkg::REG_THRESHOLD) begin
         prdata = 32'(threshold_ff);
      end else begin
         prdata = 32'(brush_size_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         brush_size_ff <= bcbt_pkg::BRUSH_SIZE_RESET;
         threshold_ff  <= bcbt_pkg::THRESHOLD_RESET;
      end else if (csr_write) begin
         if (paddr[2] == bcbt_pkg::REG_BRUSH_SIZE) begin
            brush_size_ff <= pwdata[bcbt_pkg::SIZE_W-1:0];
         end else begin
            threshold_ff <= pwdata[bcbt_pkg::THR_W-1:0];
         end
      end
   end

   bcbt_front #(
      .GRID_SIDE  (GRID_SIDE),
      .BLOCK_SIDE (BLOCK_SIDE),
      .MAX_BRUSH  (MAX_BRUSH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .brush_size (brush_size_ff),
      .clearing   (clearing),
      .q_full     (q_full),
      .q_push     (q_push),
      .q_job      (q_job)
   );

   bcbt_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (q_job),
      .full     (q_full),
      .pop      (q_pop),
      .head_job (q_head),
      .empty    (q_empty)
   );

   bcbt_back #(
      .GRID_SIDE  (GRID_SIDE),
      .BLOCK_SIDE (BLOCK_SIDE),
      .MAX_BRUSH  (MAX_BRUSH)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_empty   (q_empty),
      .q_head    (q_head),
      .q_pop     (q_pop),
      .clearing  (clearing),
      .threshold (threshold_ff),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   a_flag_only_eval: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.block_flag |-> rsp_item.done_cmd == bcbt_pkg::CMD_EVAL)
      else $error("flag raised on a command other than evaluate");

   a_busy_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> busy)
      else $error("command taken during the clearing pass");

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |=> !rsp_valid)
      else $error("result issued while memories were being cleared");

   a_no_pop_while_clearing: assert property (@(posedge clock) disable iff (reset)
      clearing |-> !q_pop)
      else $error("queue drained during the clearing pass");

endmodule

`default_nettype wire
